/* hdl/teq_pkg.sv */
// package for the timed event queue: opcodes, status codes, slot kinds, control structs
// no dependencies
package teq_pkg;

	localparam int SLOTS_DEFAULT = 16;
	localparam int TIME_W = 64;
	localparam int REP_W = 32;
	localparam int ID_W = 16;
	localparam int TAG_W = 16;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [2:0] {
		OP_ADD_IMM = 3'd0,
		OP_ADD_SIM = 3'd1,
		OP_ADD_MIS = 3'd2,
		OP_ADD_EPO = 3'd3,
		OP_REMOVE = 3'd4,
		OP_SET_TIME = 3'd5,
		OP_RUN_NEXT = 3'd6,
		OP_QUERY = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_BAD_CYCLE = 3'd1,
		ST_BAD_TIME = 3'd2,
		ST_UNKNOWN_ID = 3'd3,
		ST_WRONG_KIND = 3'd4,
		ST_TABLE_FULL = 3'd5,
		ST_NOTHING = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		KIND_IMM = 2'd0,
		KIND_SIM = 2'd1,
		KIND_MIS = 2'd2,
		KIND_EPO = 2'd3
	} kind_t;

	localparam logic [0:0] CFG_EPOCH_OFFSET = 1'b0;
	localparam logic [0:0] CFG_MISSION_START = 1'b1;

	typedef struct packed {
		logic load;
		logic scan_clear;
		logic scan_step;
		logic exec;
	} teq_cmd_t;

	typedef struct packed {
		logic scan_last;
	} teq_stat_t;

endpackage

/* hdl/teq_if.sv */
// valid/ready channel interfaces for commands and results
// depends on teq_pkg
interface teq_in_if import teq_pkg::*; ();
	logic valid;
	logic ready;
	logic [2:0] op;
	logic signed [TIME_W-1:0] event_time;
	logic signed [TIME_W-1:0] cycle_time;
	logic signed [REP_W-1:0] repeat_count;
	logic [TAG_W-1:0] action_tag;
	logic [ID_W-1:0] event_id;
	modport source (output valid, op, event_time, cycle_time, repeat_count, action_tag,
		event_id, input ready);
	modport sink (input valid, op, event_time, cycle_time, repeat_count, action_tag,
		event_id, output ready);
endinterface

interface teq_out_if import teq_pkg::*; ();
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [ID_W-1:0] result_id;
	logic signed [TIME_W-1:0] result_time;
	logic [TAG_W-1:0] run_tag;
	logic is_scheduled;
	logic has_pending;
	modport source (output valid, status, result_id, result_time, run_tag, is_scheduled,
		has_pending, input ready);
	modport sink (input valid, status, result_id, result_time, run_tag, is_scheduled,
		has_pending, output ready);
endinterface

/* hdl/teq_ctrl.sv */
// controller: load, slot scan, execute, result hold
// depends on teq_pkg
module teq_ctrl import teq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input teq_stat_t stat,
	output teq_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_EXEC = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);

	always_comb begin
		cmd.load = in_valid && in_ready;
		cmd.scan_clear = cmd.load;
		cmd.scan_step = (state_q == S_SCAN);
		cmd.exec = (state_q == S_EXEC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_SCAN;
				S_SCAN: if (stat.scan_last) state_q <= S_EXEC;
				S_EXEC: state_q <= S_DONE;
				S_DONE: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_exec_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> $past(state_q == S_SCAN && stat.scan_last))
		else $error("execute without finished scan");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");

endmodule

/* hdl/teq_dp.sv */
// datapath: slot table, scan over slots, execute and result registers
// depends on teq_pkg
module teq_dp import teq_pkg::*; #(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input teq_cmd_t cmd,
	output teq_stat_t stat,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [TIME_W-1:0] cfg_data,
	input logic [2:0] in_op,
	input logic [TIME_W-1:0] in_time,
	input logic [TIME_W-1:0] in_cycle,
	input logic [REP_W-1:0] in_rep,
	input logic [TAG_W-1:0] in_tag,
	input logic [ID_W-1:0] in_id,
	output logic [2:0] out_status,
	output logic [ID_W-1:0] out_id,
	output logic [TIME_W-1:0] out_time,
	output logic [TAG_W-1:0] out_tag,
	output logic out_sched,
	output logic out_pend
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};

	logic [SLOTS-1:0] valid_q;
	logic [ID_W-1:0] ident_q [SLOTS];
	kind_t kind_q [SLOTS];
	logic [TIME_W-1:0] due_q [SLOTS];
	logic [TIME_W-1:0] period_q [SLOTS];
	logic [REP_W-1:0] reps_q [SLOTS];
	logic [REP_W-1:0] runs_q [SLOTS];
	logic [REP_W-1:0] order_q [SLOTS];
	logic [TAG_W-1:0] action_q [SLOTS];

	logic [TIME_W-1:0] now_q, eoff_q, mstart_q;
	logic [ID_W-1:0] next_id_q;
	logic [REP_W-1:0] next_ord_q;

	logic [2:0] op_q;
	logic [TIME_W-1:0] t_q, cyc_q;
	logic [REP_W-1:0] rep_q;
	logic [TAG_W-1:0] tag_q;
	logic [ID_W-1:0] id_q;

	logic [SW-1:0] idx_q;
	logic idf_q, frf_q, imf_q, tlf_q;
	logic [SW-1:0] idi_q, fri_q, imi_q, tli_q;
	logic [REP_W-1:0] imo_q, tlo_q;
	logic [TIME_W-1:0] tld_q;

	logic cur_v, cur_tl, tl_better;
	kind_t cur_k;

	assign stat.scan_last = (idx_q == SW'(SLOTS - 1));
	assign cur_v = valid_q[idx_q];
	assign cur_k = kind_q[idx_q];
	assign cur_tl = cur_v && cur_k != KIND_IMM;
	assign tl_better = ($signed(due_q[idx_q]) < $signed(tld_q)) ||
		(due_q[idx_q] == tld_q && order_q[idx_q] < tlo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eoff_q <= '0;
			mstart_q <= '0;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_EPOCH_OFFSET) eoff_q <= cfg_data;
			else mstart_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_op;
			t_q <= in_time;
			cyc_q <= in_cycle;
			rep_q <= in_rep;
			tag_q <= in_tag;
			id_q <= in_id;
		end
	end

	// scan: one slot per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			idf_q <= 1'b0;
			frf_q <= 1'b0;
			imf_q <= 1'b0;
			tlf_q <= 1'b0;
		end else if (cmd.scan_clear) begin
			idx_q <= '0;
			idf_q <= 1'b0;
			frf_q <= 1'b0;
			imf_q <= 1'b0;
			tlf_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (!stat.scan_last) idx_q <= idx_q + 1'b1;
			if (!idf_q && cur_v && ident_q[idx_q] == id_q) begin
				idf_q <= 1'b1;
				idi_q <= idx_q;
			end
			if (!frf_q && !cur_v) begin
				frf_q <= 1'b1;
				fri_q <= idx_q;
			end
			if (cur_v && cur_k == KIND_IMM && (!imf_q || order_q[idx_q] < imo_q)) begin
				imf_q <= 1'b1;
				imi_q <= idx_q;
				imo_q <= order_q[idx_q];
			end
			if (cur_tl && (!tlf_q || tl_better)) begin
				tlf_q <= 1'b1;
				tli_q <= idx_q;
				tlo_q <= order_q[idx_q];
				tld_q <= due_q[idx_q];
			end
		end
	end

	// execute
	logic is_add, bad_time, bad_cyc;
	logic [TIME_W-1:0] due_new, mis_now, epo_now, cyc_e;
	logic [REP_W-1:0] rep_e, runs_inc;
	kind_t add_kind;

	always_comb begin
		is_add = (op_q == OP_ADD_IMM) || (op_q == OP_ADD_SIM) ||
			(op_q == OP_ADD_MIS) || (op_q == OP_ADD_EPO);
		epo_now = now_q + eoff_q;
		mis_now = epo_now - mstart_q;
		due_new = now_q;
		bad_time = 1'b0;
		add_kind = KIND_IMM;
		unique case (op_q)
			OP_ADD_SIM: begin
				bad_time = t_q[TIME_W-1];
				due_new = t_q;
				add_kind = KIND_SIM;
			end
			OP_ADD_MIS: begin
				bad_time = $signed(t_q) < $signed(mis_now);
				due_new = t_q - eoff_q + mstart_q;
				add_kind = KIND_MIS;
			end
			OP_ADD_EPO: begin
				bad_time = $signed(t_q) < $signed(epo_now);
				due_new = t_q - eoff_q;
				add_kind = KIND_EPO;
			end
			default: ;
		endcase
		cyc_e = (op_q == OP_ADD_IMM) ? '0 : cyc_q;
		rep_e = (op_q == OP_ADD_IMM) ? '0 : rep_q;
		bad_cyc = (rep_e != '0) && (cyc_e == '0 || cyc_e[TIME_W-1]);
		runs_inc = (runs_q[tli_q] == '1) ? runs_q[tli_q] : runs_q[tli_q] + 1'b1;
	end

	logic [SLOTS-1:0] valid_n;

	always_comb begin
		valid_n = valid_q;
		if (cmd.exec) begin
			unique case (op_q)
				OP_REMOVE: if (idf_q) valid_n[idi_q] = 1'b0;
				OP_SET_TIME: if (idf_q && kind_q[idi_q] != KIND_MIS &&
					kind_q[idi_q] != KIND_EPO && t_q[TIME_W-1]) valid_n[idi_q] = 1'b0;
				OP_RUN_NEXT: begin
					if (imf_q) valid_n[imi_q] = 1'b0;
					else if (tlf_q && !(reps_q[tli_q][REP_W-1] || runs_inc <= reps_q[tli_q]))
						valid_n[tli_q] = 1'b0;
				end
				OP_QUERY: ;
				default: if (!bad_time && !bad_cyc && frf_q) valid_n[fri_q] = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			now_q <= '0;
			next_id_q <= '0;
			next_ord_q <= '0;
		end else begin
			valid_q <= valid_n;
			if (cmd.exec) begin
				if (is_add && !bad_time && !bad_cyc && frf_q) begin
					next_id_q <= next_id_q + 1'b1;
					next_ord_q <= next_ord_q + 1'b1;
				end else if (op_q == OP_SET_TIME && idf_q && kind_q[idi_q] != KIND_MIS &&
					kind_q[idi_q] != KIND_EPO && !t_q[TIME_W-1]) begin
					next_ord_q <= next_ord_q + 1'b1;
				end else if (op_q == OP_RUN_NEXT && !imf_q && tlf_q) begin
					if ($signed(now_q) < $signed(tld_q)) now_q <= tld_q;
					if (reps_q[tli_q][REP_W-1] || runs_inc <= reps_q[tli_q])
						next_ord_q <= next_ord_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (is_add && !bad_time && !bad_cyc && frf_q) begin
				ident_q[fri_q] <= next_id_q;
				kind_q[fri_q] <= add_kind;
				due_q[fri_q] <= due_new;
				period_q[fri_q] <= cyc_e;
				reps_q[fri_q] <= rep_e;
				runs_q[fri_q] <= '0;
				order_q[fri_q] <= next_ord_q;
				action_q[fri_q] <= tag_q;
			end else if (op_q == OP_SET_TIME && idf_q && kind_q[idi_q] != KIND_MIS &&
				kind_q[idi_q] != KIND_EPO && !t_q[TIME_W-1]) begin
				kind_q[idi_q] <= KIND_SIM;
				due_q[idi_q] <= t_q;
				order_q[idi_q] <= next_ord_q;
			end else if (op_q == OP_RUN_NEXT && !imf_q && tlf_q) begin
				runs_q[tli_q] <= runs_inc;
				due_q[tli_q] <= tld_q + period_q[tli_q];
				order_q[tli_q] <= next_ord_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_status <= ST_OK;
			out_id <= '0;
			out_time <= '1;
			out_tag <= '0;
			out_sched <= 1'b0;
			out_pend <= |valid_n;
			unique case (op_q)
				OP_REMOVE: if (!idf_q) out_status <= ST_UNKNOWN_ID;
				OP_SET_TIME: begin
					if (!idf_q) out_status <= ST_UNKNOWN_ID;
					else if (kind_q[idi_q] == KIND_MIS || kind_q[idi_q] == KIND_EPO)
						out_status <= ST_WRONG_KIND;
				end
				OP_RUN_NEXT: begin
					if (imf_q) begin
						out_id <= ident_q[imi_q];
						out_tag <= action_q[imi_q];
						out_time <= now_q;
					end else if (tlf_q) begin
						out_id <= ident_q[tli_q];
						out_tag <= action_q[tli_q];
						out_time <= tld_q;
					end else begin
						out_status <= ST_NOTHING;
					end
				end
				OP_QUERY: begin
					out_sched <= idf_q;
					out_time <= tlf_q ? tld_q : TIME_MAX;
				end
				default: begin
					if (bad_time) out_status <= ST_BAD_TIME;
					else if (bad_cyc) out_status <= ST_BAD_CYCLE;
					else if (!frf_q) out_status <= ST_TABLE_FULL;
					else out_id <= next_id_q;
				end
			endcase
		end
	end

	a_free_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && frf_q |-> !valid_q[fri_q])
		else $error("free slot is occupied");
	a_found_id_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && idf_q |-> valid_q[idi_q])
		else $error("found slot not valid");
	a_time_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> now_q == $past(now_q))
		else $error("time moved outside execute");

endmodule

/* hdl/timed_event_queue.sv */
// timed event queue top level: controller plus slot-table datapath
// depends on teq_pkg, teq_if, teq_ctrl, teq_dp
//
// usage:
//   cmd (sink) takes one operation per transfer: op, event_time, cycle_time,
//   repeat_count, action_tag, event_id. rsp (source) returns exactly one
//   result per operation: status, result_id, result_time, run_tag,
//   is_scheduled, has_pending.
//   cfg_we/cfg_idx/cfg_data write epoch_offset (index 0) or mission_start
//   (index 1); write only while no operation is in flight.
// timing:
//   after the cmd transfer the controller scans the table slot by slot, then an
//   execute state updates it and registers the result, which rsp then offers.
//   operations are handled one at a time; a new one is taken only after the
//   result of the last one has been taken on rsp.
// reset:
//   arst_n clears all slots, simulation time, id and order counters, offsets.
// stall:
//   the result holds on rsp until taken; cmd.ready stays low meanwhile.
module timed_event_queue import teq_pkg::*; #(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	teq_in_if.sink cmd,
	teq_out_if.source rsp,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [TIME_W-1:0] cfg_data
);

	teq_cmd_t ctl;
	teq_stat_t st;

	teq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(cmd.valid),
		.in_ready(cmd.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.stat(st),
		.cmd(ctl)
	);

	teq_dp #(.SLOTS(SLOTS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(ctl),
		.stat(st),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_op(cmd.op),
		.in_time(cmd.event_time),
		.in_cycle(cmd.cycle_time),
		.in_rep(cmd.repeat_count),
		.in_tag(cmd.action_tag),
		.in_id(cmd.event_id),
		.out_status(rsp.status),
		.out_id(rsp.result_id),
		.out_time(rsp.result_time),
		.out_tag(rsp.run_tag),
		.out_sched(rsp.is_scheduled),
		.out_pend(rsp.has_pending)
	);

endmodule
